>>> hdl/jpbs_pkg.sv
`timescale 1ns / 1ps

package jpbs_pkg;

  // Geometry of one tick and one command
  localparam int Joints    = 12;
  localparam int JointIdxW = 4;
  localparam int PosW      = 16;
  localparam int TickW     = 16;
  localparam int GainW     = 16;
  localparam int InDataW   = Joints * PosW;
  localparam int OutFieldW = JointIdxW + PosW + 2 * GainW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Serial divider: one quotient bit per step
  localparam int DivSteps = 16;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    PhBlendIn = 2'd0,
    PhRise    = 2'd1,
    PhHold    = 2'd2,
    PhShift   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0] warmup;
    logic [TickW-1:0] blend_in;
    logic [TickW-1:0] rise;
    logic [TickW-1:0] hold;
    logic [TickW-1:0] shift;
    logic [GainW-1:0] stiffness;
    logic [GainW-1:0] damping;
  } cfg_t;

  // Request to the shared multiply/divide unit: quot = (mag * k) / d
  typedef struct packed {
    logic             start;
    logic [PosW-1:0]  mag;
    logic [TickW-1:0] k;
    logic [TickW-1:0] d;
  } blend_req_t;

  typedef struct packed {
    logic            done;
    logic [PosW-1:0] quot;
  } blend_rsp_t;

  // Duration of a phase; zero acts as one
  function automatic logic [TickW-1:0] dur_of(cfg_t cfg, phase_e ph);
    logic [TickW-1:0] d;
    unique case (ph)
      PhBlendIn: d = cfg.blend_in;
      PhRise:    d = cfg.rise;
      PhHold:    d = cfg.hold;
      PhShift:   d = cfg.shift;
      default:   d = cfg.shift;
    endcase
    if (d == '0) d = TickW'(1);
    return d;
  endfunction

  // Keyframe A, Q4.12
  function automatic logic signed [PosW-1:0] pose_a(logic [JointIdxW-1:0] j);
    logic signed [PosW-1:0] p;
    case (j) inside
      4'd1, 4'd4, 4'd7, 4'd10: p = 16'sd5571;
      4'd2, 4'd5, 4'd8, 4'd11: p = -16'sd10854;
      4'd6:                    p = -16'sd819;
      4'd9:                    p = 16'sd819;
      default:                 p = '0;
    endcase
    return p;
  endfunction

  // Keyframe B, Q4.12
  function automatic logic signed [PosW-1:0] pose_b(logic [JointIdxW-1:0] j);
    logic signed [PosW-1:0] p;
    case (j) inside
      4'd1, 4'd4, 4'd7, 4'd10: p = 16'sd2744;
      4'd2, 4'd5, 4'd8, 4'd11: p = -16'sd5325;
      default:                 p = '0;
    endcase
    return p;
  endfunction

  // Keyframe C, Q4.12
  function automatic logic signed [PosW-1:0] pose_c(logic [JointIdxW-1:0] j);
    logic signed [PosW-1:0] p;
    case (j) inside
      4'd1, 4'd4, 4'd7, 4'd10: p = 16'sd5571;
      4'd2, 4'd5, 4'd8, 4'd11: p = -16'sd10854;
      4'd0:                    p = -16'sd1434;
      4'd3:                    p = 16'sd1434;
      4'd6:                    p = -16'sd2048;
      4'd9:                    p = 16'sd2048;
      default:                 p = '0;
    endcase
    return p;
  endfunction

endpackage

>>> hdl/joint_pose_blend_sequencer.sv
`timescale 1ns / 1ps

// Joint pose blend sequencer. Each input item is one control tick carrying the
// measured angles of twelve joints (Q4.12). Ticks inside the warmup window are
// consumed and give no result; the first active tick latches the measured
// angles as start pose, and every active tick emits twelve command items,
// joint 0 first, tlast on joint 11, with the phase on tuser. An active tick
// first steps the phase, then works through the joints in turn; for each it
// forms a + ((b - a) * k) / d with the serial divider of the shared blend unit
// (one quotient bit per cycle). The input is not ready while a tick is in
// work. The output register lets the next joint be computed, and the next tick
// be taken, while a command item waits. Configuration is written through
// cfg_we_i / cfg_idx_i / cfg_data_i and must only change while the block idles.

module joint_pose_blend_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [15:0]                    cfg_data_i,
  // Tick input
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // meas_pos_0 [15:0], meas_pos_1 [31:16], ... meas_pos_11 [191:176]
  input  logic [jpbs_pkg::InDataW-1:0]   s_axis_tdata_i,
  // Command output
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // joint_index [3:0], cmd_position [19:4], cmd_stiffness [35:20],
  // cmd_damping [51:36], zero fill [55:52]
  output logic [jpbs_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // active_phase [1:0]
  output logic [1:0]                     m_axis_tuser_o,
  // last_joint
  output logic                           m_axis_tlast_o
);

  typedef enum logic [2:0] {
    CfgWarmup,
    CfgBlendIn,
    CfgRise,
    CfgHold,
    CfgShift,
    CfgStiffness,
    CfgDamping
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SIdle,
    SPhase,
    SSel,
    SDiv,
    SOut
  } state_e;

  localparam int PosW = jpbs_pkg::PosW;
  localparam int JIW  = jpbs_pkg::JointIdxW;

  jpbs_pkg::cfg_t             cfg_q;
  logic signed [PosW-1:0]     start_pose_q [jpbs_pkg::Joints];

  state_e                     state_q;
  logic [JIW-1:0]             joint_q;
  logic signed [PosW-1:0]     a_q;
  logic                       neg_q;

  logic                       m_valid_q;
  logic [JIW-1:0]             out_idx_q;
  logic [PosW-1:0]            out_pos_q;
  logic [jpbs_pkg::GainW-1:0] out_stiff_q;
  logic [jpbs_pkg::GainW-1:0] out_damp_q;
  jpbs_pkg::phase_e           out_phase_q;
  logic                       out_last_q;

  logic                       tick;
  logic                       active;
  logic                       capture;
  logic                       advance;
  jpbs_pkg::phase_e           phase;
  logic [jpbs_pkg::TickW-1:0] ticks;

  logic signed [PosW-1:0]     pa;
  logic signed [PosW-1:0]     pb;
  logic [PosW:0]              diff;
  logic                       neg;
  logic [PosW-1:0]            mag;
  logic [PosW:0]              delta;
  logic [PosW:0]              pos;
  logic                       out_free;
  logic                       last;

  jpbs_pkg::blend_req_t       req;
  jpbs_pkg::blend_rsp_t       rsp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warmup    <= 16'd500;
      cfg_q.blend_in  <= 16'd500;
      cfg_q.rise      <= 16'd500;
      cfg_q.hold      <= 16'd1000;
      cfg_q.shift     <= 16'd900;
      cfg_q.stiffness <= 16'd15360;
      cfg_q.damping   <= 16'd1280;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgWarmup:    cfg_q.warmup    <= cfg_data_i;
        CfgBlendIn:   cfg_q.blend_in  <= cfg_data_i;
        CfgRise:      cfg_q.rise      <= cfg_data_i;
        CfgHold:      cfg_q.hold      <= cfg_data_i;
        CfgShift:     cfg_q.shift     <= cfg_data_i;
        CfgStiffness: cfg_q.stiffness <= cfg_data_i;
        CfgDamping:   cfg_q.damping   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tick bookkeeping: warmup, start capture, phase and tick count
  assign tick    = s_axis_tvalid_i && (state_q == SIdle);
  assign advance = (state_q == SPhase);

  jpbs_tick u_tick (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .tick_i    (tick),
    .advance_i (advance),
    .active_o  (active),
    .capture_o (capture),
    .phase_o   (phase),
    .ticks_o   (ticks)
  );

  // Latch the start pose on the first active tick
  always_ff @(posedge clk_i) begin
    if (capture) begin
      for (int j = 0; j < jpbs_pkg::Joints; j++) begin
        start_pose_q[j] <= s_axis_tdata_i[j*PosW +: PosW];
      end
    end
  end

  // Pick the blend endpoints of the current joint
  always_comb begin
    unique case (phase)
      jpbs_pkg::PhBlendIn: begin
        pa = start_pose_q[joint_q];
        pb = jpbs_pkg::pose_a(joint_q);
      end
      jpbs_pkg::PhRise: begin
        pa = jpbs_pkg::pose_a(joint_q);
        pb = jpbs_pkg::pose_b(joint_q);
      end
      jpbs_pkg::PhHold: begin
        pa = jpbs_pkg::pose_b(joint_q);
        pb = jpbs_pkg::pose_b(joint_q);
      end
      jpbs_pkg::PhShift: begin
        pa = jpbs_pkg::pose_b(joint_q);
        pb = jpbs_pkg::pose_c(joint_q);
      end
      default: begin
        pa = '0;
        pb = '0;
      end
    endcase
  end

  // Split b - a into sign and magnitude for the unsigned divider
  assign diff = {pb[PosW-1], pb} - {pa[PosW-1], pa};
  assign neg  = diff[PosW];
  assign mag  = neg ? PosW'(-diff) : diff[PosW-1:0];

  assign req.start = (state_q == SSel);
  assign req.mag   = mag;
  assign req.k     = ticks;
  assign req.d     = jpbs_pkg::dur_of(cfg_q, phase);

  jpbs_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Restore the sign of the quotient and add the start point
  assign delta    = neg_q ? -{1'b0, rsp.quot} : {1'b0, rsp.quot};
  assign pos      = {a_q[PosW-1], a_q} + delta;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign last     = (joint_q == JIW'(jpbs_pkg::Joints - 1));

  // Joint sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      joint_q     <= '0;
      a_q         <= '0;
      neg_q       <= 1'b0;
      m_valid_q   <= 1'b0;
      out_idx_q   <= '0;
      out_pos_q   <= '0;
      out_stiff_q <= '0;
      out_damp_q  <= '0;
      out_phase_q <= jpbs_pkg::PhBlendIn;
      out_last_q  <= 1'b0;
    end else begin
      // Load a new command item, else drop the one taken by the receiver
      if (state_q == SOut && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (s_axis_tvalid_i && active) state_q <= SPhase;
        end
        SPhase: begin
          joint_q <= '0;
          state_q <= SSel;
        end
        SSel: begin
          a_q     <= pa;
          neg_q   <= neg;
          state_q <= SDiv;
        end
        SDiv: begin
          if (rsp.done) state_q <= SOut;
        end
        SOut: begin
          if (out_free) begin
            out_idx_q   <= joint_q;
            out_pos_q   <= pos[PosW-1:0];
            out_stiff_q <= cfg_q.stiffness;
            out_damp_q  <= cfg_q.damping;
            out_phase_q <= phase;
            out_last_q  <= last;
            if (last) begin
              state_q <= SIdle;
            end else begin
              joint_q <= joint_q + 1'b1;
              state_q <= SSel;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == SIdle);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = jpbs_pkg::OutDataW'({out_damp_q, out_stiff_q, out_pos_q, out_idx_q});
  assign m_axis_tuser_o  = out_phase_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> hdl/jpbs_blend.sv
`timescale 1ns / 1ps

module jpbs_blend (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  jpbs_pkg::blend_req_t   req_i,
  output jpbs_pkg::blend_rsp_t   rsp_o
);

  typedef enum logic [1:0] {
    UIdle,
    UMul,
    UDiv
  } state_e;

  state_e                          state_q;
  logic [jpbs_pkg::PosW-1:0]       mag_q;
  logic [jpbs_pkg::TickW-1:0]      k_q;
  logic [jpbs_pkg::TickW-1:0]      d_q;
  logic [jpbs_pkg::TickW-1:0]      rem_q;
  logic [jpbs_pkg::DivSteps-1:0]   num_q;
  logic [jpbs_pkg::DivCntW-1:0]    cnt_q;
  logic                            done_q;

  logic [2*jpbs_pkg::TickW-1:0]    prod;
  logic [jpbs_pkg::TickW:0]        trial;
  logic [jpbs_pkg::TickW:0]        trial_sub;
  logic                            fits;

  // Product of magnitude and tick count; quotient always fits 16 bits since k <= d
  assign prod      = (2*jpbs_pkg::TickW)'(mag_q) * (2*jpbs_pkg::TickW)'(k_q);
  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem_q, num_q[jpbs_pkg::DivSteps-1]};
  assign trial_sub = trial - {1'b0, d_q};
  assign fits      = trial >= {1'b0, d_q};

  // Sequence multiply then one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UIdle;
      mag_q   <= '0;
      k_q     <= '0;
      d_q     <= '0;
      rem_q   <= '0;
      num_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        UIdle: begin
          done_q <= 1'b0;
          if (req_i.start) begin
            mag_q   <= req_i.mag;
            k_q     <= req_i.k;
            d_q     <= req_i.d;
            state_q <= UMul;
          end
        end
        UMul: begin
          done_q  <= 1'b0;
          rem_q   <= prod[2*jpbs_pkg::TickW-1:jpbs_pkg::TickW];
          num_q   <= prod[jpbs_pkg::TickW-1:0];
          cnt_q   <= '0;
          state_q <= UDiv;
        end
        UDiv: begin
          rem_q  <= fits ? trial_sub[jpbs_pkg::TickW-1:0] : trial[jpbs_pkg::TickW-1:0];
          num_q  <= {num_q[jpbs_pkg::DivSteps-2:0], fits};
          cnt_q  <= cnt_q + 1'b1;
          done_q <= (cnt_q == jpbs_pkg::DivCntW'(jpbs_pkg::DivSteps - 1));
          if (cnt_q == jpbs_pkg::DivCntW'(jpbs_pkg::DivSteps - 1)) begin
            state_q <= UIdle;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= UIdle;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == UIdle)
    else $error("blend unit started while busy");

  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == UDiv)
    else $error("blend unit done without a divide step");

endmodule

>>> hdl/jpbs_tick.sv
`timescale 1ns / 1ps

module jpbs_tick (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  jpbs_pkg::cfg_t              cfg_i,
  input  logic                        tick_i,
  input  logic                        advance_i,
  output logic                        active_o,
  output logic                        capture_o,
  output jpbs_pkg::phase_e            phase_o,
  output logic [jpbs_pkg::TickW-1:0]  ticks_o
);

  logic [jpbs_pkg::TickW-1:0] warm_cnt_q, warm_cnt_d;
  logic                       started_q, started_d;
  jpbs_pkg::phase_e           phase_q, phase_d;
  logic [jpbs_pkg::TickW-1:0] ticks_q, ticks_d;

  logic [jpbs_pkg::TickW-1:0] warm_inc;
  logic                       reach;
  logic [jpbs_pkg::TickW:0]   k_c;
  jpbs_pkg::phase_e           p_c;

  // Saturating warmup count and the first active tick
  assign warm_inc  = (warm_cnt_q == '1) ? warm_cnt_q : warm_cnt_q + 1'b1;
  assign reach     = warm_inc >= cfg_i.warmup;
  assign active_o  = started_q | reach;
  assign capture_o = tick_i & ~started_q & reach;

  always_comb begin
    warm_cnt_d = warm_cnt_q;
    started_d  = started_q;
    if (tick_i && !started_q) begin
      warm_cnt_d = warm_inc;
      if (reach) started_d = 1'b1;
    end
  end

  // Step the tick count and cascade through phases that are already complete
  always_comb begin
    k_c = {1'b0, ticks_q} + 1'b1;
    p_c = phase_q;
    for (int i = 0; i < 3; i++) begin
      if (p_c != jpbs_pkg::PhShift && k_c >= {1'b0, jpbs_pkg::dur_of(cfg_i, p_c)}) begin
        p_c = jpbs_pkg::phase_e'(p_c + 2'd1);
        k_c = (jpbs_pkg::TickW + 1)'(1);
      end
    end
    if (p_c == jpbs_pkg::PhShift &&
        k_c > {1'b0, jpbs_pkg::dur_of(cfg_i, jpbs_pkg::PhShift)}) begin
      k_c = {1'b0, jpbs_pkg::dur_of(cfg_i, jpbs_pkg::PhShift)};
    end
    phase_d = advance_i ? p_c : phase_q;
    ticks_d = advance_i ? k_c[jpbs_pkg::TickW-1:0] : ticks_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_cnt_q <= '0;
      started_q  <= 1'b0;
      phase_q    <= jpbs_pkg::PhBlendIn;
      ticks_q    <= '0;
    end else begin
      warm_cnt_q <= warm_cnt_d;
      started_q  <= started_d;
      phase_q    <= phase_d;
      ticks_q    <= ticks_d;
    end
  end

  assign phase_o = phase_q;
  assign ticks_o = ticks_q;

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("start pose capture lost");

  a_shift_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == jpbs_pkg::PhShift |=> phase_q == jpbs_pkg::PhShift)
    else $error("left the final phase");

  a_step_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(ticks_q) && $stable(phase_q))
    else $error("phase state moved without a tick step");

endmodule

>>> tb/sv/joint_pose_blend_sequencer_tb.sv
`timescale 1ns / 1ps

module joint_pose_blend_sequencer_tb;

  localparam int SettleCycles = 300;
  localparam int CycleLimit   = 1000000;
  localparam int LongHoldoff  = 4000;

  typedef enum int {
    RegWarmup    = 0,
    RegBlendIn   = 1,
    RegRise      = 2,
    RegHold      = 3,
    RegShift     = 4,
    RegStiffness = 5,
    RegDamping   = 6
  } reg_idx_e;

  typedef struct {
    logic [jpbs_pkg::JointIdxW-1:0] joint;
    logic [jpbs_pkg::PosW-1:0]      position;
    logic [jpbs_pkg::GainW-1:0]     stiffness;
    logic [jpbs_pkg::GainW-1:0]     damping;
    jpbs_pkg::phase_e               phase;
    logic                           last;
  } joint_cmd_t;

  // Trajectory tracker: follows warmup, phase and tick count, and holds the
  // joint commands still owed by the block
  class joint_cmd_tracker;
    logic [15:0]       regs [7];
    int                warmup_count;
    bit                started;
    int                start_pose [jpbs_pkg::Joints];
    jpbs_pkg::phase_e  phase;
    int                phase_ticks;
    int                key_a [jpbs_pkg::Joints];
    int                key_b [jpbs_pkg::Joints];
    int                key_c [jpbs_pkg::Joints];
    joint_cmd_t        cmds_due [$];
    int                mismatches;

    function new();
      regs = '{16'd500, 16'd500, 16'd500, 16'd1000, 16'd900, 16'd15360, 16'd1280};
      warmup_count = 0;
      started = 1'b0;
      phase = jpbs_pkg::PhBlendIn;
      phase_ticks = 0;
      mismatches = 0;
      key_a = '{0, 5571, -10854, 0, 5571, -10854, -819, 5571, -10854, 819, 5571, -10854};
      key_b = '{0, 2744, -5325, 0, 2744, -5325, 0, 2744, -5325, 0, 2744, -5325};
      key_c = '{-1434, 5571, -10854, 1434, 5571, -10854,
                -2048, 5571, -10854, 2048, 5571, -10854};
    endfunction

    function void set_reg(reg_idx_e idx, logic [15:0] value);
      regs[idx] = value;
    endfunction

    // Duration of a phase in ticks; zero counts as one
    function int phase_len(jpbs_pkg::phase_e ph);
      int d;
      case (ph)
        jpbs_pkg::PhBlendIn: d = regs[RegBlendIn];
        jpbs_pkg::PhRise:    d = regs[RegRise];
        jpbs_pkg::PhHold:    d = regs[RegHold];
        default:             d = regs[RegShift];
      endcase
      return (d == 0) ? 1 : d;
    endfunction

    // a + ((b - a) * k) / d, quotient truncated toward zero
    function int ramp(int a, int b, int k, int d);
      longint diff;
      diff = longint'(b) - longint'(a);
      return int'(longint'(a) + (diff * k) / d);
    endfunction

    function void take_tick(logic [jpbs_pkg::InDataW-1:0] angles);
      int k;
      int pos;
      joint_cmd_t cmd;
      // Count warmup ticks, then latch the start pose once
      if (!started) begin
        if (warmup_count < 16'hFFFF) warmup_count++;
        if (warmup_count < int'(regs[RegWarmup])) return;
        for (int j = 0; j < jpbs_pkg::Joints; j++) begin
          start_pose[j] = int'($signed(angles[j*jpbs_pkg::PosW +: jpbs_pkg::PosW]));
        end
        started = 1'b1;
      end
      // Advance the phase, possibly across several phases in one tick
      k = phase_ticks + 1;
      while (phase != jpbs_pkg::PhShift && k >= phase_len(phase)) begin
        phase = jpbs_pkg::phase_e'(phase + 1);
        k = 1;
      end
      if (phase == jpbs_pkg::PhShift && k > phase_len(jpbs_pkg::PhShift)) begin
        k = phase_len(jpbs_pkg::PhShift);
      end
      phase_ticks = k;
      for (int j = 0; j < jpbs_pkg::Joints; j++) begin
        case (phase)
          jpbs_pkg::PhBlendIn:
            pos = ramp(start_pose[j], key_a[j], k, phase_len(jpbs_pkg::PhBlendIn));
          jpbs_pkg::PhRise:
            pos = ramp(key_a[j], key_b[j], k, phase_len(jpbs_pkg::PhRise));
          jpbs_pkg::PhHold:
            pos = key_b[j];
          default:
            pos = ramp(key_b[j], key_c[j], k, phase_len(jpbs_pkg::PhShift));
        endcase
        cmd.joint     = jpbs_pkg::JointIdxW'(j);
        cmd.position  = pos[jpbs_pkg::PosW-1:0];
        cmd.stiffness = regs[RegStiffness];
        cmd.damping   = regs[RegDamping];
        cmd.phase     = phase;
        cmd.last      = (j == jpbs_pkg::Joints - 1);
        cmds_due.push_back(cmd);
      end
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        if (mismatches < 40) begin
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
        mismatches++;
      end
    endfunction

    function void match_cmd(logic [jpbs_pkg::OutDataW-1:0] data, logic [1:0] user,
                            logic last);
      joint_cmd_t want;
      if (cmds_due.size() == 0) begin
        if (mismatches < 40) begin
          $display("%0t: unexpected command, expected none actual tdata %0h tuser %0h",
                   $time, data, user);
        end
        mismatches++;
        return;
      end
      want = cmds_due.pop_front();
      field_check("joint_index", 16'(want.joint), 16'(data[3:0]));
      field_check("cmd_position", want.position, data[19:4]);
      field_check("cmd_stiffness", want.stiffness, data[35:20]);
      field_check("cmd_damping", want.damping, data[51:36]);
      field_check("active_phase", 16'(want.phase), 16'(user));
      field_check("last_joint", 16'(want.last), 16'(last));
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [2:0]                      cfg_idx_i = '0;
  logic [15:0]                     cfg_data_i = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [jpbs_pkg::InDataW-1:0]    s_axis_tdata_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [jpbs_pkg::OutDataW-1:0]   m_axis_tdata_o;
  logic [1:0]                      m_axis_tuser_o;
  logic                            m_axis_tlast_o;

  joint_cmd_tracker     trk;
  int                   cycles = 0;
  int                   tx_gap_pct = 0;
  bit                   rx_stalls = 1'b1;
  int                   rx_hold_len = 0;
  int                   rx_stall_left = 0;

  joint_pose_blend_sequencer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sample both item handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        trk.match_cmd(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end
      if (s_axis_tvalid_i && s_axis_tready_o) trk.take_tick(s_axis_tdata_i);
    end
  end

  // Command receiver: long hold-off on request, else random stall bursts
  always @(negedge clk_i) begin
    if (rx_hold_len > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold_len = rx_hold_len - 1;
    end else if (rx_stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_stall_left = rx_stall_left - 1;
    end else if (rx_stalls && $urandom_range(0, 99) < 15) begin
      m_axis_tready_i <= 1'b0;
      rx_stall_left = $urandom_range(0, 17);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  function automatic logic [jpbs_pkg::InDataW-1:0] random_angles();
    logic [jpbs_pkg::InDataW-1:0] angles;
    for (int j = 0; j < jpbs_pkg::Joints; j++) begin
      case ($urandom_range(0, 9))
        0:       angles[j*jpbs_pkg::PosW +: jpbs_pkg::PosW] = 16'h8000;
        1:       angles[j*jpbs_pkg::PosW +: jpbs_pkg::PosW] = 16'h7FFF;
        2:       angles[j*jpbs_pkg::PosW +: jpbs_pkg::PosW] = 16'h0000;
        3:       angles[j*jpbs_pkg::PosW +: jpbs_pkg::PosW] = 16'hFFFF;
        default: angles[j*jpbs_pkg::PosW +: jpbs_pkg::PosW] = 16'($urandom);
      endcase
    end
    return angles;
  endfunction

  // Write one register while the block idles, keep the tracker in step
  task automatic write_reg(reg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= 3'(idx);
    cfg_data_i <= value;
    trk.set_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Offer one tick, after an optional idle burst, and wait for its handshake
  task automatic send_tick(logic [jpbs_pkg::InDataW-1:0] angles);
    int gap;
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= angles;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic run_ticks(int count);
    repeat (count) send_tick(random_angles());
  endtask

  // Drop valid, wait for every owed command, then let the block go idle
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (trk.cmds_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [jpbs_pkg::InDataW-1:0] start_angles;
    logic [15:0]                  start_lanes [jpbs_pkg::Joints];
    trk = new();
    start_lanes = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h8000,
                    16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 16'h7FFF};
    for (int j = 0; j < jpbs_pkg::Joints; j++) begin
      start_angles[j*jpbs_pkg::PosW +: jpbs_pkg::PosW] = start_lanes[j];
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Short warmup: 29 ticks with no commands, extremes first
    write_reg(RegWarmup, 16'd30);
    tx_gap_pct = 10;
    send_tick({jpbs_pkg::Joints{16'h0000}});
    send_tick({jpbs_pkg::Joints{16'hFFFF}});
    send_tick({jpbs_pkg::Joints{16'h8000}});
    send_tick({jpbs_pkg::Joints{16'h7FFF}});
    run_ticks(25);
    // Capture the start pose from extreme angles, then two blend-in steps
    send_tick(start_angles);
    run_ticks(2);
    settle();

    // Warmup change after start must not matter; short blend-in, full stiffness, zero damping
    write_reg(RegWarmup, 16'hFFFF);
    write_reg(RegBlendIn, 16'd64);
    write_reg(RegStiffness, 16'hFFFF);
    write_reg(RegDamping, 16'h0000);
    tx_gap_pct = 30;
    run_ticks($urandom_range(40, 52));
    settle();

    // Zero durations: one tick cascades from blend-in past rise into hold
    write_reg(RegBlendIn, 16'h0000);
    write_reg(RegRise, 16'h0000);
    write_reg(RegHold, 16'd6);
    write_reg(RegStiffness, 16'($urandom));
    write_reg(RegDamping, 16'($urandom));
    run_ticks(4);
    settle();

    // Hold lowered below its count, then the longest shift
    write_reg(RegHold, 16'd3);
    write_reg(RegShift, 16'hFFFF);
    write_reg(RegWarmup, 16'h0000);
    run_ticks(20);
    settle();

    // Shift of zero clamps the count to one
    write_reg(RegShift, 16'h0000);
    write_reg(RegStiffness, 16'h0000);
    write_reg(RegDamping, 16'hFFFF);
    run_ticks(4);
    settle();

    // Ramp into pose C and saturate, with the receiver holding off at first
    write_reg(RegShift, 16'd50);
    write_reg(RegStiffness, 16'($urandom));
    write_reg(RegDamping, 16'($urandom));
    rx_hold_len = LongHoldoff;
    run_ticks(60);
    settle();

    // Last stretch at full rate on both sides, shift lowered below the count
    tx_gap_pct = 0;
    rx_stalls = 1'b0;
    write_reg(RegShift, 16'($urandom_range(2, 20)));
    write_reg(RegStiffness, 16'($urandom));
    write_reg(RegDamping, 16'($urandom));
    run_ticks(50);
    settle();

    if (trk.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/jpbs_pkg.sv
hdl/jpbs_blend.sv
hdl/jpbs_tick.sv
hdl/joint_pose_blend_sequencer.sv
tb/sv/joint_pose_blend_sequencer_tb.sv
